// ===== design/pict_pkg.sv =====
package pict_pkg;

    localparam logic [4:0] NONE_LIVE = 5'd16;

    localparam logic [4:0] RG_HVCT  = 5'd0;
    localparam logic [4:0] RG_HVCTW = 5'd1;
    localparam logic [4:0] RG_IPNDL = 5'd6;
    localparam logic [4:0] RG_IPNDH = 5'd7;
    localparam logic [4:0] RG_ISRVL = 5'd8;
    localparam logic [4:0] RG_ISRVH = 5'd9;
    localparam logic [4:0] RG_IMSKL = 5'd10;
    localparam logic [4:0] RG_IMSKH = 5'd11;
    localparam logic [4:0] RG_FPRTL = 5'd14;
    localparam logic [4:0] RG_FPRTH = 5'd15;
    localparam logic [4:0] RG_MCTL  = 5'd16;
    localparam logic [4:0] RG_CIPTR = 5'd18;
    localparam logic [4:0] RG_CCTL  = 5'd22;
    localparam logic [4:0] RG_CICTL = 5'd23;
    localparam logic [4:0] RG_CSVL0 = 5'd24;
    localparam logic [4:0] RG_CSVL1 = 5'd25;
    localparam logic [4:0] RG_CSVH0 = 5'd26;
    localparam logic [4:0] RG_CSVH1 = 5'd27;
    localparam logic [4:0] RG_CCVL0 = 5'd28;
    localparam logic [4:0] RG_CCVL1 = 5'd29;
    localparam logic [4:0] RG_CCVH0 = 5'd30;
    localparam logic [4:0] RG_CCVH1 = 5'd31;

    localparam int unsigned RF_DEPTH = 32;

    localparam int unsigned MCTL_FREEZE = 3;
    localparam int unsigned MCTL_HOLD   = 7;
    localparam int unsigned CCTL_DIV4   = 6;

    localparam logic [7:0] CCTL_LOW_SEL   = 8'h84;
    localparam logic [7:0] CCTL_LOW_RUN   = 8'h04;
    localparam logic [7:0] CCTL_HIGH_SEL  = 8'h88;
    localparam logic [7:0] CCTL_HIGH_RUN  = 8'h08;
    localparam logic [7:0] CCTL_CHAIN     = 8'h88;
    localparam logic [7:0] CI_LOW_FLAG    = 8'h04;
    localparam logic [7:0] CI_LOW_OVR     = 8'h08;
    localparam logic [7:0] CI_HIGH_FLAG   = 8'h40;
    localparam logic [7:0] CI_HIGH_OVR    = 8'h80;
    localparam logic [7:0] CI_LOW_IRQ     = 8'h06;
    localparam logic [7:0] CI_HIGH_IRQ    = 8'h60;
    localparam logic [7:0] CI_LOW_CLR     = 8'hFB;
    localparam logic [7:0] CI_HIGH_CLR    = 8'hBF;

    typedef enum logic [1:0] {
        MODE_READ  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_RAISE = 2'd2,
        MODE_TICK  = 2'd3
    } pict_mode_t;

    typedef struct packed {
        logic [15:0] ipnd;
        logic [15:0] isrv;
        logic [7:0]  hvct;
        logic [4:0]  live;
        logic        irq;
    } pict_ctl_t;

    typedef struct packed {
        logic       found;
        logic [3:0] idx;
    } pict_top_t;

    function automatic pict_top_t pict_top_bit(input logic [15:0] v);
        pict_top_t res;
        res = '0;
        for (int i = 0; i < 16; i++) begin
            if (v[i]) begin
                res.found = 1'b1;
                res.idx   = 4'(i);
            end
        end
        return res;
    endfunction

    function automatic pict_ctl_t pict_evaluate(input pict_ctl_t st, input logic [15:0] imsk);
        pict_top_t n;
        pict_top_t t;
        pict_ctl_t res;
        res = st;
        n = pict_top_bit(st.ipnd & ~imsk);
        t = pict_top_bit(st.isrv);
        if (n.found && (st.live == NONE_LIVE || !t.found || n.idx > t.idx)) begin
            res.irq  = 1'b1;
            res.live = {1'b0, n.idx};
            res.hvct = {st.hvct[7:4], n.idx};
        end
        return res;
    endfunction

    function automatic pict_ctl_t pict_raise(input pict_ctl_t st, input logic [3:0] line,
                                             input logic [15:0] imsk, input logic freeze);
        pict_ctl_t res;
        res = st;
        if (!freeze) begin
            res.ipnd = st.ipnd | (16'd1 << line);
            res = pict_evaluate(res, imsk);
        end
        return res;
    endfunction

endpackage

// ===== design/priority_interrupt_controller_timer_core.sv =====
// Each input transfer is captured in the input register, then all work is done
// in one pass into the result register.
// Throughput: one item per cycle while m_tready holds; the input register lets a new
// item in while a finished result waits.
// Reset (aresetn low, synchronous): register file to zero except masks and
// CIPTR at 0xFF, counters and prescaler cleared, no level live, irq low.
module priority_interrupt_controller_timer_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,  // reg_index[4:0], return_cycle[5], write_data[13:6],
                                  // line_number[17:14], zero [23:18]
    input  pict_pkg::pict_mode_t s_tuser,  // mode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata   // read_data[7:0], irq_request[8], zero [15:9]
);
    import pict_pkg::*;

    logic       in_valid_reg;
    pict_mode_t in_mode_reg;
    logic [4:0] in_index_reg;
    logic       in_ret_reg;
    logic [7:0] in_wdata_reg;
    logic [3:0] in_line_reg;

    logic       out_valid_reg;
    logic [7:0] out_data_reg;
    logic       out_irq_reg;

    logic [7:0]  rf_reg  [RF_DEPTH];
    logic [7:0]  rf_next [RF_DEPTH];
    logic [15:0] low_reg, low_next;
    logic [15:0] high_reg, high_next;
    logic [1:0]  pre_reg, pre_next;
    logic [4:0]  live_reg;
    logic        irq_reg;

    pict_ctl_t   st;
    logic [15:0] imsk;
    logic [7:0]  ci;
    logic [7:0]  cc;
    logic [7:0]  ciptr;
    logic [7:0]  mctl;
    logic [3:0]  fprt;
    logic [7:0]  rd;
    logic        step;
    logic        proc_fire;

    assign proc_fire = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || proc_fire;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {7'd0, out_irq_reg, out_data_reg};

    always_comb begin
        rf_next   = rf_reg;
        low_next  = low_reg;
        high_next = high_reg;
        pre_next  = pre_reg;
        imsk      = {rf_reg[RG_IMSKH], rf_reg[RG_IMSKL]};
        st.ipnd   = {rf_reg[RG_IPNDH], rf_reg[RG_IPNDL]};
        st.isrv   = {rf_reg[RG_ISRVH], rf_reg[RG_ISRVL]};
        st.hvct   = rf_reg[RG_HVCT];
        st.live   = live_reg;
        st.irq    = irq_reg;
        ci        = rf_reg[RG_CICTL];
        cc        = rf_reg[RG_CCTL];
        ciptr     = rf_reg[RG_CIPTR];
        mctl      = rf_reg[RG_MCTL];
        fprt      = rf_reg[RG_FPRTL][3:0];
        rd        = 8'd0;
        step      = 1'b0;
        case (in_mode_reg)
            MODE_READ: begin
                case (in_index_reg)
                    RG_HVCT: begin
                        if (in_ret_reg) begin
                            if (st.live != NONE_LIVE) begin
                                if (st.live[3:0] == ciptr[3:0]) ci = ci & CI_LOW_CLR;
                                if (st.live[3:0] == ciptr[7:4]) ci = ci & CI_HIGH_CLR;
                                st.hvct = st.hvct | 8'h0F;
                                st.isrv = st.isrv & ~(16'd1 << st.live[3:0]);
                                st.live = NONE_LIVE;
                                st = pict_evaluate(st, imsk);
                            end
                            rd = st.hvct | 8'h0F;
                        end else begin
                            if (st.live != NONE_LIVE) begin
                                st.ipnd = st.ipnd & ~(16'd1 << st.live[3:0]);
                                st.isrv = st.isrv | (16'd1 << st.live[3:0]);
                            end
                            st.irq = 1'b0;
                            st = pict_evaluate(st, imsk);
                            rd = st.hvct;
                        end
                    end
                    RG_HVCTW: rd = st.hvct;
                    RG_FPRTL: rd = fprt[3] ? 8'd0 : (8'd1 << fprt[2:0]);
                    RG_FPRTH: rd = fprt[3] ? (8'd1 << fprt[2:0]) : 8'd0;
                    default:  rd = rf_reg[in_index_reg];
                endcase
            end
            MODE_WRITE: begin
                case (in_index_reg)
                    RG_HVCT, RG_IPNDL, RG_IPNDH, RG_FPRTH: ;
                    RG_HVCTW: st.hvct = {in_wdata_reg[7:4], st.hvct[3:0]};
                    RG_ISRVL: st.isrv[7:0] = in_wdata_reg;
                    RG_ISRVH: st.isrv[15:8] = in_wdata_reg;
                    RG_IMSKL: begin
                        imsk[7:0] = in_wdata_reg;
                        rf_next[RG_IMSKL] = in_wdata_reg;
                    end
                    RG_IMSKH: begin
                        imsk[15:8] = in_wdata_reg;
                        rf_next[RG_IMSKH] = in_wdata_reg;
                    end
                    RG_FPRTL: rf_next[RG_FPRTL] = {4'd0, in_wdata_reg[3:0]};
                    RG_CICTL: begin
                        if (in_wdata_reg[0]) ci[3:0] = in_wdata_reg[3:0];
                        if (in_wdata_reg[4]) ci[7:4] = in_wdata_reg[7:4];
                    end
                    default: rf_next[in_index_reg] = in_wdata_reg;
                endcase
                st = pict_evaluate(st, imsk);
            end
            MODE_RAISE: begin
                st = pict_raise(st, in_line_reg, imsk, mctl[MCTL_FREEZE]);
            end
            default: begin
                if (cc[CCTL_DIV4]) begin
                    if (pre_reg == 2'd3) begin
                        pre_next = 2'd0;
                        step     = 1'b1;
                    end else begin
                        pre_next = pre_reg + 2'd1;
                    end
                end else begin
                    pre_next = 2'd0;
                    step     = 1'b1;
                end
                if (step) begin
                    if ((cc & CCTL_LOW_SEL) == CCTL_LOW_RUN) begin
                        low_next = low_next - 16'd1;
                        if (low_next == 16'd0) begin
                            ci = ci | (((ci & CI_LOW_FLAG) != 8'd0) ? CI_LOW_OVR : CI_LOW_FLAG);
                            low_next = {rf_reg[RG_CSVL1], rf_reg[RG_CSVL0]};
                        end
                    end
                    if ((cc & CCTL_HIGH_SEL) == CCTL_HIGH_RUN) begin
                        high_next = high_next - 16'd1;
                        if (high_next == 16'd0) begin
                            ci = ci | (((ci & CI_HIGH_FLAG) != 8'd0) ? CI_HIGH_OVR
                                                                      : CI_HIGH_FLAG);
                            high_next = {rf_reg[RG_CSVH1], rf_reg[RG_CSVH0]};
                        end
                    end
                    if ((cc & CCTL_HIGH_SEL) == CCTL_CHAIN) begin
                        if (low_next == 16'd0) begin
                            high_next = high_next - 16'd1;
                            if (high_next == 16'd0) begin
                                ci = ci | (((ci & CI_HIGH_FLAG) != 8'd0) ? CI_HIGH_OVR
                                                                          : CI_HIGH_FLAG);
                                low_next  = {rf_reg[RG_CSVL1], rf_reg[RG_CSVL0]};
                                high_next = {rf_reg[RG_CSVH1], rf_reg[RG_CSVH0]};
                            end
                        end
                        low_next = low_next - 16'd1;
                    end
                    if ((ci & CI_HIGH_IRQ) == CI_HIGH_IRQ)
                        st = pict_raise(st, ciptr[7:4], imsk, mctl[MCTL_FREEZE]);
                    if ((ci & CI_LOW_IRQ) == CI_LOW_IRQ)
                        st = pict_raise(st, ciptr[3:0], imsk, mctl[MCTL_FREEZE]);
                end
                if (!mctl[MCTL_HOLD]) begin
                    rf_next[RG_CCVL0] = low_next[7:0];
                    rf_next[RG_CCVL1] = low_next[15:8];
                    rf_next[RG_CCVH0] = high_next[7:0];
                    rf_next[RG_CCVH1] = high_next[15:8];
                end
            end
        endcase
        rf_next[RG_HVCT]  = st.hvct;
        rf_next[RG_IPNDL] = st.ipnd[7:0];
        rf_next[RG_IPNDH] = st.ipnd[15:8];
        rf_next[RG_ISRVL] = st.isrv[7:0];
        rf_next[RG_ISRVH] = st.isrv[15:8];
        rf_next[RG_CICTL] = ci;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < RF_DEPTH; i++) begin
                rf_reg[i] <= (i == RG_IMSKL || i == RG_IMSKH || i == RG_CIPTR) ? 8'hFF
                                                                               : 8'd0;
            end
            low_reg  <= 16'd0;
            high_reg <= 16'd0;
            pre_reg  <= 2'd0;
            live_reg <= NONE_LIVE;
            irq_reg  <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (proc_fire) begin
                in_valid_reg <= 1'b0;
            end
            if (proc_fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (proc_fire) begin
                rf_reg   <= rf_next;
                low_reg  <= low_next;
                high_reg <= high_next;
                pre_reg  <= pre_next;
                live_reg <= st.live;
                irq_reg  <= st.irq;
            end
        end
    end

    // hold payload until the next transfer
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_mode_reg  <= s_tuser;
            in_index_reg <= s_tdata[4:0];
            in_ret_reg   <= s_tdata[5];
            in_wdata_reg <= s_tdata[13:6];
            in_line_reg  <= s_tdata[17:14];
        end
        if (proc_fire) begin
            out_data_reg <= rd;
            out_irq_reg  <= st.irq;
        end
    end

endmodule
